>>> rtl/core/at_ipd_receive_parser_defines.svh
// Assertion macros for the +IPD receive parser.
// Included by at_ipd_receive_parser.sv; no other dependencies.
`ifndef AT_IPD_RECEIVE_PARSER_DEFINES_SVH
`define AT_IPD_RECEIVE_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ATIPD_ASSERT_NOW(label, clk, rst, cond, consq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consq)) \
      else $error(msg);

// Next-cycle implication.
`define ATIPD_ASSERT_NEXT(label, clk, rst, cond, consq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consq)) \
      else $error(msg);

`endif

>>> rtl/core/atipd_pkg.sv
// Shared widths, codes and the result record of the +IPD receive parser.
// No dependencies.
package atipd_pkg;

   // Field widths
   localparam int unsigned OP_W      = 2;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned IDX_W     = 12;
   localparam int unsigned MSG_LEN_W = 12;
   localparam int unsigned CLIENT_W  = 8;
   localparam int unsigned EV_W      = 3;
   localparam int unsigned CNT_W     = 16;
   localparam int unsigned RUN_W     = 4;

   // Defaults and fixed run length
   localparam int unsigned MAX_LENGTH_DEF = 4095;
   localparam logic [RUN_W-1:0] RESET_RUN = RUN_W'(10);

   // Operation codes
   localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_TAKE  = 2'd2;

   // Command events
   localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EV_W-1:0] EV_PREV    = 3'd1;
   localparam logic [EV_W-1:0] EV_NEXT    = 3'd2;
   localparam logic [EV_W-1:0] EV_ROLL    = 3'd3;
   localparam logic [EV_W-1:0] EV_STATIC  = 3'd4;
   localparam logic [EV_W-1:0] EV_COLLECT = 3'd5;

   // Characters
   localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_S      = 8'h53;
   localparam logic [BYTE_W-1:0] CH_E      = 8'h45;
   localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ESC    = 8'h7F;
   localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
   localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
   localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_BRACK  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

   // One result beat
   typedef struct packed {
      logic                 payload_valid;
      logic [BYTE_W-1:0]    payload_byte;
      logic [IDX_W-1:0]     payload_index;
      logic                 message_done;
      logic [CLIENT_W-1:0]  client_id;
      logic [MSG_LEN_W-1:0] message_length;
      logic                 message_ready;
      logic                 send_ok;
      logic [EV_W-1:0]      command_event;
      logic                 reset_request;
   } rsp_type;

endpackage

>>> rtl/core/atipd_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on atipd_pkg.
interface atipd_req_if;
   logic                         valid;
   logic                         ready;
   logic [atipd_pkg::OP_W-1:0]   op;
   logic [atipd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, op, rx_byte, input ready);
   modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface atipd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            payload_valid;
   logic [atipd_pkg::BYTE_W-1:0]    payload_byte;
   logic [atipd_pkg::IDX_W-1:0]     payload_index;
   logic                            message_done;
   logic [atipd_pkg::CLIENT_W-1:0]  client_id;
   logic [atipd_pkg::MSG_LEN_W-1:0] message_length;
   logic                            message_ready;
   logic                            send_ok;
   logic [atipd_pkg::EV_W-1:0]      command_event;
   logic                            reset_request;

   modport source (output valid, payload_valid, payload_byte, payload_index, message_done,
                   client_id, message_length, message_ready, send_ok, command_event,
                   reset_request, input ready);
   modport sink   (input valid, payload_valid, payload_byte, payload_index, message_done,
                   client_id, message_length, message_ready, send_ok, command_event,
                   reset_request, output ready);
endinterface

>>> rtl/core/at_ipd_receive_parser.sv
// Usage notes for the +IPD receive parser.
// req_ch carries one beat per UART byte or command: op 0 is a received byte,
// op 1 clears the received message and accumulators, op 2 reads and clears
// the send-ok flag, op 3 does nothing. rsp_ch returns exactly one beat per
// request beat: the payload byte with its index and last mark when the byte
// belongs to a frame payload, plus client number, declared length, the ready
// and send-ok flags, a command event and a reset request.
// The result beat is registered and valid in the cycle after the request beat
// is taken. Throughput: one beat per cycle while results are taken; the parser
// state updates in a single pass of combinational logic from the state
// registers into the result register, so back-to-back beats pass without gaps.
// If the receiver stalls, the result register holds its beat and req_ch.ready
// drops until the beat is taken; in the cycle it is taken a new request is
// accepted.
// Synchronous reset clears all parser flags, accumulators, the payload count,
// the 0x7F run and the result valid.
// Depends on atipd_pkg, atipd_if.sv and at_ipd_receive_parser_defines.svh.
`include "at_ipd_receive_parser_defines.svh"

module at_ipd_receive_parser #(
   parameter int unsigned MAX_LENGTH = atipd_pkg::MAX_LENGTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   atipd_req_if.sink     req_ch,
   atipd_rsp_if.source   rsp_ch
);
   import atipd_pkg::*;

   localparam int unsigned LEN_W   = $clog2(MAX_LENGTH + 1);
   localparam int unsigned LMUL_W  = LEN_W + 4;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH);

   // Parser state
   logic                line_start_ff, line_start_in;
   logic                in_frame_ff, in_frame_in;
   logic                seen_comma_ff, seen_comma_in;
   logic                rd_client_ff, rd_client_in;
   logic                rd_length_ff, rd_length_in;
   logic                rd_payload_ff, rd_payload_in;
   logic [CLIENT_W-1:0] client_ff, client_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ready_flag_ff, ready_flag_in;
   logic                send_ff, send_in;
   logic [RUN_W-1:0]    run_ff, run_in;

   // Result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic                accept;
   logic [BYTE_W-1:0]   rx;
   logic                is_digit;
   logic [3:0]          digit;
   logic [LMUL_W-1:0]   len_mul;
   logic [LEN_W-1:0]    len_sat;
   logic [11:0]         cli_mul;
   logic [CLIENT_W-1:0] cli_sat;
   logic [CNT_W-1:0]    count_inc;
   logic [RUN_W-1:0]    run_inc;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign rx           = req_ch.rx_byte;

   // Decimal accumulate with saturation
   assign is_digit = (rx >= CH_ZERO) && (rx <= CH_NINE);
   assign digit    = 4'(rx - CH_ZERO);
   assign len_mul  = (LMUL_W'(length_ff) << 3) + (LMUL_W'(length_ff) << 1) + LMUL_W'(digit);
   assign len_sat  = (len_mul > LMUL_W'(MAX_LENGTH)) ? LEN_MAX : len_mul[LEN_W-1:0];
   assign cli_mul  = (12'(client_ff) << 3) + (12'(client_ff) << 1) + 12'(digit);
   assign cli_sat  = (cli_mul > 12'd255) ? 8'hFF : cli_mul[CLIENT_W-1:0];

   assign count_inc = (count_ff == {CNT_W{1'b1}}) ? count_ff : count_ff + 1'b1;
   assign run_inc   = run_ff + 1'b1;

   // Next state and result for one beat
   always_comb begin
      logic frame_mid;
      line_start_in = line_start_ff;
      in_frame_in   = in_frame_ff;
      seen_comma_in = seen_comma_ff;
      rd_client_in  = rd_client_ff;
      rd_length_in  = rd_length_ff;
      rd_payload_in = rd_payload_ff;
      client_in     = client_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      ready_flag_in = ready_flag_ff;
      send_in       = send_ff;
      run_in        = run_ff;
      frame_mid     = in_frame_ff;
      rsp_in        = '0;

      case (req_ch.op)
         OP_BYTE: begin
            // single-byte commands
            case (rx)
               CH_DOLLAR: rsp_in.command_event = EV_PREV;
               CH_HASH:   rsp_in.command_event = EV_NEXT;
               CH_AMP:    rsp_in.command_event = EV_ROLL;
               CH_STAR:   rsp_in.command_event = EV_STATIC;
               CH_BRACK:  rsp_in.command_event = EV_COLLECT;
               default:   rsp_in.command_event = EV_NONE;
            endcase

            if (rx == CH_LF) begin
               line_start_in = 1'b1;
            end else if (rx == CH_CR) begin
               line_start_in = 1'b0;
            end else begin
               if (in_frame_ff) begin
                  if (!rd_payload_ff) begin
                     // header: client, length, colon
                     if (rx != CH_COLON && rd_length_ff && is_digit)
                        length_in = len_sat;
                     if (rx == CH_COMMA && seen_comma_ff && rd_client_ff && !rd_length_ff) begin
                        rd_length_in = 1'b1;
                        rd_client_in = 1'b0;
                     end
                     if (rx == CH_COMMA && !seen_comma_ff && !rd_client_ff) begin
                        rd_client_in  = 1'b1;
                        seen_comma_in = 1'b1;
                     end
                     if (rx != CH_COMMA && rd_client_ff && is_digit)
                        client_in = cli_sat;
                     if (rx == CH_COLON) begin
                        if (length_ff == '0) begin
                           ready_flag_in = 1'b1;
                           in_frame_in   = 1'b0;
                           seen_comma_in = 1'b0;
                           rd_client_in  = 1'b0;
                           rd_length_in  = 1'b0;
                           rd_payload_in = 1'b0;
                           frame_mid     = 1'b0;
                        end else begin
                           rd_payload_in = 1'b1;
                        end
                     end
                  end else begin
                     // payload byte
                     rsp_in.payload_valid = 1'b1;
                     rsp_in.payload_byte  = rx;
                     rsp_in.payload_index = IDX_W'(count_ff);
                     count_in             = count_inc;
                     if (count_inc >= CNT_W'(length_ff)) begin
                        rsp_in.message_done = 1'b1;
                        ready_flag_in = 1'b1;
                        in_frame_in   = 1'b0;
                        seen_comma_in = 1'b0;
                        rd_client_in  = 1'b0;
                        rd_length_in  = 1'b0;
                        rd_payload_in = 1'b0;
                        frame_mid     = 1'b0;
                     end
                  end
               end
               // line start outside a frame
               if (!frame_mid && line_start_ff) begin
                  if (rx == CH_PLUS)
                     in_frame_in = 1'b1;
                  else if (rx == CH_E)
                     send_in = 1'b0;
                  else if (rx == CH_S)
                     send_in = 1'b1;
                  line_start_in = 1'b0;
               end
            end

            // run of escape bytes
            if (rx == CH_ESC) begin
               if (run_inc == RESET_RUN) begin
                  run_in               = '0;
                  rsp_in.reset_request = 1'b1;
               end else begin
                  run_in = run_inc;
               end
            end else begin
               run_in = '0;
            end
            rsp_in.send_ok = send_in;
         end
         OP_CLEAR: begin
            ready_flag_in  = 1'b0;
            client_in      = '0;
            length_in      = '0;
            count_in       = '0;
            rsp_in.send_ok = send_ff;
         end
         OP_TAKE: begin
            rsp_in.send_ok = send_ff;
            send_in        = 1'b0;
         end
         default: begin
            rsp_in.send_ok = send_ff;
         end
      endcase

      rsp_in.client_id      = client_in;
      rsp_in.message_length = MSG_LEN_W'(length_in);
      rsp_in.message_ready  = ready_flag_in;
   end

   // State, result valid and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff <= 1'b0;
         in_frame_ff   <= 1'b0;
         seen_comma_ff <= 1'b0;
         rd_client_ff  <= 1'b0;
         rd_length_ff  <= 1'b0;
         rd_payload_ff <= 1'b0;
         client_ff     <= '0;
         length_ff     <= '0;
         count_ff      <= '0;
         ready_flag_ff <= 1'b0;
         send_ff       <= 1'b0;
         run_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            line_start_ff <= line_start_in;
            in_frame_ff   <= in_frame_in;
            seen_comma_ff <= seen_comma_in;
            rd_client_ff  <= rd_client_in;
            rd_length_ff  <= rd_length_in;
            rd_payload_ff <= rd_payload_in;
            client_ff     <= client_in;
            length_ff     <= length_in;
            count_ff      <= count_in;
            ready_flag_ff <= ready_flag_in;
            send_ff       <= send_in;
            run_ff        <= run_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // Result channel
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.payload_valid  = rsp_ff.payload_valid;
   assign rsp_ch.payload_byte   = rsp_ff.payload_byte;
   assign rsp_ch.payload_index  = rsp_ff.payload_index;
   assign rsp_ch.message_done   = rsp_ff.message_done;
   assign rsp_ch.client_id      = rsp_ff.client_id;
   assign rsp_ch.message_length = rsp_ff.message_length;
   assign rsp_ch.message_ready  = rsp_ff.message_ready;
   assign rsp_ch.send_ok        = rsp_ff.send_ok;
   assign rsp_ch.command_event  = rsp_ff.command_event;
   assign rsp_ch.reset_request  = rsp_ff.reset_request;

   // Checks
   `ATIPD_ASSERT_NOW(a_payload_in_frame, clock, reset, rd_payload_ff, in_frame_ff, "payload phase outside a frame")
   `ATIPD_ASSERT_NOW(a_header_phase, clock, reset, rd_client_ff, !rd_length_ff && seen_comma_ff, "client and length phases overlap")
   `ATIPD_ASSERT_NOW(a_done_sets_ready, clock, reset, rsp_valid_ff && rsp_ff.message_done, rsp_ff.payload_valid && rsp_ff.message_ready, "frame end without ready flag")
   `ATIPD_ASSERT_NEXT(a_reset_run_restarts, clock, reset, rsp_ch.valid && rsp_ch.reset_request && $past(accept), run_ff == '0 || $past(accept), "escape run not restarted")

endmodule
